// ===== rtl/core/hlc_pkg.sv =====
// shared types and constants of the hashed lru tag store
`default_nettype none
package hlc_pkg;

  // fixed field widths
  localparam int OPC_W   = 2;
  localparam int KEY_W   = 160;
  localparam int SIZE_W  = 24;
  localparam int MAXE_W  = 12;
  localparam int MAXB_W  = 25;
  localparam int BYTES_W = 26;
  localparam int LIM_W   = 13;
  localparam int OUTC_W  = 12;
  localparam int CFGI_W  = 1;

  // configuration register indexes and reset values
  localparam logic [CFGI_W-1:0] REG_MAX_ENTRIES = 1'b0;
  localparam logic [CFGI_W-1:0] REG_MAX_BYTES   = 1'b1;
  localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 12'd2048;
  localparam logic [MAXB_W-1:0] MAX_BYTES_RST   = 25'd16777216;

  // operation codes
  localparam logic [OPC_W-1:0] OP_PROBE = 2'd0;
  localparam logic [OPC_W-1:0] OP_GET   = 2'd1;
  localparam logic [OPC_W-1:0] OP_PUT   = 2'd2;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd3;

  // controller states
  typedef enum logic [4:0] {
    S_RST_CLR, S_IDLE, S_CLR, S_LK_BH, S_LK_HEAD, S_WK_RD, S_WK_CMP,
    S_UN_RD, S_UN_WR, S_PU_W1, S_PU_W2, S_PUT_CHK, S_EV_CHK,
    S_DR_KEY, S_DR_LAT, S_DR_BH, S_DR_HEAD, S_DR_WRD, S_DR_WCMP, S_DR_FIN,
    S_AL, S_AL_W, S_IN_BH, S_IN_WR, S_DONE
  } hlc_state_t;

  // datapath commands
  typedef enum logic [4:0] {
    C_NOP, C_CLR, C_ACCEPT, C_LK_BH, C_LK_HEAD, C_WK_RD, C_WK_CMP,
    C_UN_RD, C_UN_WR, C_PU_W1, C_PU_W2, C_DR_SEL, C_DR_KEY, C_DR_LAT,
    C_DR_BH, C_DR_HEAD, C_DR_WRD, C_DR_WCMP, C_DR_FIN, C_AL, C_AL_W,
    C_IN_BH, C_IN_WR, C_OUT
  } hlc_cmd_t;

  // datapath status
  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic key_match;
    logic chain_null;
    logic chain_is_tgt;
    logic bh_null;
    logic bh_is_tgt;
    logic cur_is_newest;
    logic store_full;
    logic need_evict;
    logic free_avail;
    logic hwm_avail;
    logic clr_last;
    logic found;
    logic out_valid;
  } hlc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/hlc_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none
module hlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/hlc_ctrl.sv =====
// controller state machine sequencing clears, lookups, lru moves, inserts and evictions
`default_nettype none
module hlc_ctrl
  import hlc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [OPC_W-1:0] in_opcode,
  input  wire logic             out_stall,
  input  wire hlc_stat_t        stat,
  output hlc_cmd_t              cmd,
  output logic                  in_stall
);

  hlc_state_t state_r, state_nxt;
  logic drop_mode_r, drop_mode_nxt;
  logic drop_pre_r, drop_pre_nxt;
  hlc_state_t miss_state;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RST_CLR;
      drop_mode_r <= 1'b0;
      drop_pre_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drop_mode_r <= drop_mode_nxt;
      drop_pre_r  <= drop_pre_nxt;
    end
  end

  // a miss goes on to insert only for a put
  assign miss_state = (stat.op == OP_PUT) ? S_PUT_CHK : S_DONE;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    drop_mode_nxt = drop_mode_r;
    drop_pre_nxt  = drop_pre_r;
    cmd           = C_NOP;
    in_stall      = 1'b1;
    unique case (state_r)
      S_RST_CLR: begin
        cmd = C_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd       = C_ACCEPT;
          state_nxt = (in_opcode == OP_CLEAR) ? S_CLR : S_LK_BH;
        end
      end
      S_CLR: begin
        cmd = C_CLR;
        if (stat.clr_last) state_nxt = S_DONE;
      end
      S_LK_BH: begin
        cmd       = C_LK_BH;
        state_nxt = S_LK_HEAD;
      end
      S_LK_HEAD: begin
        cmd       = C_LK_HEAD;
        state_nxt = stat.bh_null ? miss_state : S_WK_RD;
      end
      S_WK_RD: begin
        cmd       = C_WK_RD;
        state_nxt = S_WK_CMP;
      end
      S_WK_CMP: begin
        cmd = C_WK_CMP;
        if (stat.key_match) begin
          if (stat.op == OP_PROBE || stat.cur_is_newest) begin
            state_nxt = S_DONE;
          end else begin
            drop_mode_nxt = 1'b0;
            state_nxt     = S_UN_RD;
          end
        end else if (stat.chain_null) begin
          state_nxt = miss_state;
        end else begin
          state_nxt = S_WK_RD;
        end
      end
      S_UN_RD: begin
        cmd       = C_UN_RD;
        state_nxt = S_UN_WR;
      end
      S_UN_WR: begin
        cmd       = C_UN_WR;
        state_nxt = drop_mode_r ? S_DR_FIN : S_PU_W1;
      end
      S_PU_W1: begin
        cmd       = C_PU_W1;
        state_nxt = S_PU_W2;
      end
      S_PU_W2: begin
        cmd       = C_PU_W2;
        state_nxt = stat.found ? S_DONE : S_EV_CHK;
      end
      S_PUT_CHK: begin
        cmd = C_DR_SEL;
        if (stat.store_full) begin
          drop_pre_nxt = 1'b1;
          state_nxt    = S_DR_KEY;
        end else begin
          state_nxt = S_AL;
        end
      end
      S_EV_CHK: begin
        cmd = C_DR_SEL;
        if (stat.need_evict) begin
          drop_pre_nxt = 1'b0;
          state_nxt    = S_DR_KEY;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DR_KEY: begin
        cmd       = C_DR_KEY;
        state_nxt = S_DR_LAT;
      end
      S_DR_LAT: begin
        cmd       = C_DR_LAT;
        state_nxt = S_DR_BH;
      end
      S_DR_BH: begin
        cmd       = C_DR_BH;
        state_nxt = S_DR_HEAD;
      end
      S_DR_HEAD: begin
        cmd = C_DR_HEAD;
        if (stat.bh_is_tgt || stat.bh_null) begin
          drop_mode_nxt = 1'b1;
          state_nxt     = S_UN_RD;
        end else begin
          state_nxt = S_DR_WRD;
        end
      end
      S_DR_WRD: begin
        cmd       = C_DR_WRD;
        state_nxt = S_DR_WCMP;
      end
      S_DR_WCMP: begin
        cmd = C_DR_WCMP;
        if (stat.chain_is_tgt || stat.chain_null) begin
          drop_mode_nxt = 1'b1;
          state_nxt     = S_UN_RD;
        end else begin
          state_nxt = S_DR_WRD;
        end
      end
      S_DR_FIN: begin
        cmd       = C_DR_FIN;
        state_nxt = drop_pre_r ? S_AL : S_EV_CHK;
      end
      S_AL: begin
        cmd = C_AL;
        if (stat.free_avail)     state_nxt = S_AL_W;
        else if (stat.hwm_avail) state_nxt = S_IN_BH;
        else                     state_nxt = S_EV_CHK;
      end
      S_AL_W: begin
        cmd       = C_AL_W;
        state_nxt = S_IN_BH;
      end
      S_IN_BH: begin
        cmd       = C_IN_BH;
        state_nxt = S_IN_WR;
      end
      S_IN_WR: begin
        cmd       = C_IN_WR;
        state_nxt = S_PU_W1;
      end
      S_DONE: begin
        if (!stat.out_valid || !out_stall) begin
          cmd       = C_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/hlc_dp.sv =====
// datapath: key, size and link memories, bucket heads, free list, counters, result register
`default_nettype none
module hlc_dp
  import hlc_pkg::*;
#(
  parameter int CAPACITY = 2048,
  parameter int BUCKETS  = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hlc_cmd_t          cmd,
  output hlc_stat_t              stat,
  input  wire logic              cfg_we,
  input  wire logic [CFGI_W-1:0] cfg_index,
  input  wire logic [MAXB_W-1:0] cfg_wdata,
  input  wire logic [OPC_W-1:0]  in_opcode,
  input  wire logic [63:0]       in_key_low,
  input  wire logic [63:0]       in_key_mid,
  input  wire logic [31:0]       in_key_high,
  input  wire logic [SIZE_W-1:0] in_entry_size,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic                   out_found,
  output logic [SIZE_W-1:0]      out_hit_size,
  output logic [OUTC_W-1:0]      out_evicted,
  output logic [OUTC_W-1:0]      out_entries_held,
  output logic [MAXB_W-1:0]      out_bytes_held
);

  localparam int PW = $clog2(CAPACITY);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = CW + 1;
  localparam logic [15:0] BMASK = 16'(BUCKETS - 1);
  localparam logic [PW:0] NIL = {1'b1, {PW{1'b0}}};

  // configuration
  logic [MAXE_W-1:0] max_e_r;
  logic [MAXB_W-1:0] max_b_r;

  // control state
  logic [PW:0]      newest_r, oldest_r;
  logic [CW-1:0]    count_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [PW:0]      hwm_r, fsp_r, fsp_dec;
  logic [BW-1:0]    clr_cnt_r;
  logic             out_valid_r;

  // item payload
  logic [OPC_W-1:0]  op_r;
  logic [KEY_W-1:0]  key_r;
  logic [SIZE_W-1:0] size_r;
  logic [PW:0]       cur_r, prev_r, dnext_r;
  logic [PW-1:0]     tgt_r;
  logic [BW-1:0]     dbkt_r;
  logic [SIZE_W-1:0] dsize_r, hit_r;
  logic              found_r;
  logic [EW-1:0]     ev_r;
  logic              out_found_r;
  logic [SIZE_W-1:0] out_hit_r;
  logic [OUTC_W-1:0] out_ev_r, out_cnt_r;
  logic [MAXB_W-1:0] out_bytes_r;

  // memory ports
  logic              key_we, size_we, chain_we, bh_we, older_we, newer_we, free_we;
  logic [PW-1:0]     key_raddr, chain_raddr, chain_waddr, older_waddr, newer_waddr;
  logic [PW-1:0]     free_raddr, free_waddr;
  logic [BW-1:0]     bh_raddr, bh_waddr;
  logic [PW:0]       chain_wdata, bh_wdata, older_wdata, newer_wdata;
  logic [KEY_W-1:0]  key_rdata;
  logic [SIZE_W-1:0] size_rdata;
  logic [PW:0]       chain_rdata, bh_rdata, older_rdata, newer_rdata;
  logic [PW-1:0]     free_rdata;

  // derived values
  logic [BW-1:0]     in_bkt, rd_bkt;
  logic [LIM_W-1:0]  lim, max_e_ext;
  logic              key_match;

  assign in_bkt    = BW'(key_r[15:0] & BMASK);
  assign rd_bkt    = BW'(key_rdata[15:0] & BMASK);
  assign fsp_dec   = fsp_r - (PW+1)'(1);
  assign max_e_ext = LIM_W'(max_e_r);
  assign lim       = (max_e_ext < LIM_W'(CAPACITY)) ? max_e_ext : LIM_W'(CAPACITY);
  assign key_match = (key_rdata == key_r);

  // status toward the controller
  always_comb begin
    stat.op            = op_r;
    stat.key_match     = key_match;
    stat.chain_null    = chain_rdata[PW];
    stat.chain_is_tgt  = (chain_rdata == {1'b0, tgt_r});
    stat.bh_null       = bh_rdata[PW];
    stat.bh_is_tgt     = (bh_rdata == {1'b0, tgt_r});
    stat.cur_is_newest = (newest_r == cur_r);
    stat.store_full    = (count_r >= CW'(CAPACITY)) && !oldest_r[PW];
    stat.need_evict    = !oldest_r[PW] &&
                         ((LIM_W'(count_r) > lim) ||
                          ((bytes_r > BYTES_W'(max_b_r)) && (count_r > CW'(1))));
    stat.free_avail    = (fsp_r != '0);
    stat.hwm_avail     = (hwm_r < (PW+1)'(CAPACITY));
    stat.clr_last      = (clr_cnt_r == BW'(BUCKETS - 1));
    stat.found         = found_r;
    stat.out_valid     = out_valid_r;
  end

  // memory address and write selection
  always_comb begin
    key_we      = 1'b0;
    size_we     = 1'b0;
    chain_we    = 1'b0;
    bh_we       = 1'b0;
    older_we    = 1'b0;
    newer_we    = 1'b0;
    free_we     = 1'b0;
    key_raddr   = cur_r[PW-1:0];
    chain_raddr = cur_r[PW-1:0];
    chain_waddr = tgt_r;
    chain_wdata = bh_rdata;
    bh_raddr    = in_bkt;
    bh_waddr    = in_bkt;
    bh_wdata    = {1'b0, tgt_r};
    older_waddr = tgt_r;
    older_wdata = newest_r;
    newer_waddr = tgt_r;
    newer_wdata = NIL;
    free_raddr  = fsp_dec[PW-1:0];
    free_waddr  = fsp_r[PW-1:0];
    unique case (cmd)
      C_CLR: begin
        bh_we    = 1'b1;
        bh_waddr = clr_cnt_r;
        bh_wdata = NIL;
      end
      C_DR_KEY: begin
        key_raddr   = tgt_r;
        chain_raddr = tgt_r;
      end
      C_DR_BH: bh_raddr = dbkt_r;
      C_DR_HEAD: begin
        bh_we    = stat.bh_is_tgt;
        bh_waddr = dbkt_r;
        bh_wdata = dnext_r;
      end
      C_DR_WRD: chain_raddr = prev_r[PW-1:0];
      C_DR_WCMP: begin
        chain_raddr = prev_r[PW-1:0];
        chain_we    = stat.chain_is_tgt;
        chain_waddr = prev_r[PW-1:0];
        chain_wdata = dnext_r;
      end
      C_UN_WR: begin
        older_we    = !newer_rdata[PW];
        older_waddr = newer_rdata[PW-1:0];
        older_wdata = older_rdata;
        newer_we    = !older_rdata[PW];
        newer_waddr = older_rdata[PW-1:0];
        newer_wdata = newer_rdata;
      end
      C_PU_W1: begin
        older_we = 1'b1;
        newer_we = 1'b1;
      end
      C_PU_W2: begin
        newer_we    = !newest_r[PW];
        newer_waddr = newest_r[PW-1:0];
        newer_wdata = {1'b0, tgt_r};
      end
      C_DR_FIN: free_we = 1'b1;
      C_IN_WR: begin
        key_we   = 1'b1;
        size_we  = 1'b1;
        chain_we = 1'b1;
        bh_we    = 1'b1;
      end
      default: ;
    endcase
  end

  // configuration, lru ends, counters, free list and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_e_r     <= MAX_ENTRIES_RST;
      max_b_r     <= MAX_BYTES_RST;
      newest_r    <= NIL;
      oldest_r    <= NIL;
      count_r     <= '0;
      bytes_r     <= '0;
      hwm_r       <= '0;
      fsp_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_ENTRIES: max_e_r <= cfg_wdata[MAXE_W-1:0];
          REG_MAX_BYTES:   max_b_r <= cfg_wdata;
          default: ;
        endcase
      end
      // result valid: set by a new result, cleared when taken
      if (cmd == C_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (cmd)
        C_CLR: begin
          clr_cnt_r <= stat.clr_last ? '0 : clr_cnt_r + BW'(1);
          newest_r  <= NIL;
          oldest_r  <= NIL;
          count_r   <= '0;
          bytes_r   <= '0;
          hwm_r     <= '0;
          fsp_r     <= '0;
        end
        C_UN_WR: begin
          if (newer_rdata[PW]) newest_r <= older_rdata;
          if (older_rdata[PW]) oldest_r <= newer_rdata;
        end
        C_PU_W2: begin
          if (newest_r[PW]) oldest_r <= {1'b0, tgt_r};
          newest_r <= {1'b0, tgt_r};
        end
        C_DR_FIN: begin
          fsp_r <= fsp_r + (PW+1)'(1);
          if (count_r != '0) count_r <= count_r - CW'(1);
          bytes_r <= (bytes_r >= BYTES_W'(dsize_r)) ? bytes_r - BYTES_W'(dsize_r) : '0;
        end
        C_AL: begin
          if (fsp_r != '0) fsp_r <= fsp_dec;
          else if (stat.hwm_avail) hwm_r <= hwm_r + (PW+1)'(1);
        end
        C_IN_WR: begin
          count_r <= count_r + CW'(1);
          bytes_r <= bytes_r + BYTES_W'(size_r);
        end
        default: ;
      endcase
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      C_ACCEPT: begin
        op_r    <= in_opcode;
        key_r   <= {in_key_high, in_key_mid, in_key_low};
        size_r  <= in_entry_size;
        found_r <= 1'b0;
        hit_r   <= '0;
        ev_r    <= '0;
      end
      C_LK_HEAD: cur_r <= bh_rdata;
      C_WK_CMP: begin
        if (key_match) begin
          found_r <= 1'b1;
          hit_r   <= size_rdata;
          tgt_r   <= cur_r[PW-1:0];
        end else begin
          cur_r <= chain_rdata;
        end
      end
      C_DR_SEL: tgt_r <= oldest_r[PW-1:0];
      C_DR_LAT: begin
        dbkt_r  <= rd_bkt;
        dsize_r <= size_rdata;
        dnext_r <= chain_rdata;
      end
      C_DR_HEAD: prev_r <= bh_rdata;
      C_DR_WCMP: prev_r <= chain_rdata;
      C_DR_FIN:  ev_r   <= ev_r + EW'(1);
      C_AL: begin
        if (fsp_r == '0) tgt_r <= hwm_r[PW-1:0];
      end
      C_AL_W: tgt_r <= free_rdata;
      C_OUT: begin
        out_found_r <= found_r;
        out_hit_r   <= hit_r;
        out_ev_r    <= OUTC_W'(ev_r);
        out_cnt_r   <= OUTC_W'(count_r);
        out_bytes_r <= MAXB_W'(bytes_r);
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_hit_size     = out_hit_r;
  assign out_evicted      = out_ev_r;
  assign out_entries_held = out_cnt_r;
  assign out_bytes_held   = out_bytes_r;

  // key store
  hlc_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(tgt_r), .wdata(key_r),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  // size store
  hlc_ram #(.WIDTH(SIZE_W), .DEPTH(CAPACITY)) u_size_ram (
    .clk(clk), .we(size_we), .waddr(tgt_r), .wdata(size_r),
    .raddr(key_raddr), .rdata(size_rdata)
  );

  // bucket chain links
  hlc_ram #(.WIDTH(PW+1), .DEPTH(CAPACITY)) u_chain_ram (
    .clk(clk), .we(chain_we), .waddr(chain_waddr), .wdata(chain_wdata),
    .raddr(chain_raddr), .rdata(chain_rdata)
  );

  // bucket heads
  hlc_ram #(.WIDTH(PW+1), .DEPTH(BUCKETS)) u_bh_ram (
    .clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(bh_raddr), .rdata(bh_rdata)
  );

  // lru links toward the oldest end
  hlc_ram #(.WIDTH(PW+1), .DEPTH(CAPACITY)) u_older_ram (
    .clk(clk), .we(older_we), .waddr(older_waddr), .wdata(older_wdata),
    .raddr(tgt_r), .rdata(older_rdata)
  );

  // lru links toward the newest end
  hlc_ram #(.WIDTH(PW+1), .DEPTH(CAPACITY)) u_newer_ram (
    .clk(clk), .we(newer_we), .waddr(newer_waddr), .wdata(newer_wdata),
    .raddr(tgt_r), .rdata(newer_rdata)
  );

  // stack of released slots
  hlc_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(tgt_r),
    .raddr(free_raddr), .rdata(free_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/core/hashed_lru_cache_with_byte_budget.sv =====
// top level of the hashed lru tag store with entry and byte budgets
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall   | opcode, key_low/mid/high, entry_size
//  out_    | output    | out_valid / out_stall | found, hit_size, evicted, entries_held, bytes_held
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// probe or get: walks the bucket chain; a touch then moves a hit to the newest end.
// put of a new key: walks the bucket chain, reuses a released slot when one is free, and
// walks the bucket chain of each entry that it evicts;
// the time an item takes grows with the bucket chain entries walked.
// clear: one bucket head written per cycle.
// after reset the same bucket head pass runs over all BUCKETS heads (256 by default) with in_stall high.
// one item at a time; a new item is taken while the previous result waits in the output register.
`default_nettype none
module hashed_lru_cache_with_byte_budget
  import hlc_pkg::*;
#(
  parameter int CAPACITY = 2048,
  parameter int BUCKETS  = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OPC_W-1:0]  in_opcode,
  input  wire logic [63:0]       in_key_low,
  input  wire logic [63:0]       in_key_mid,
  input  wire logic [31:0]       in_key_high,
  input  wire logic [SIZE_W-1:0] in_entry_size,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_found,
  output logic [SIZE_W-1:0]      out_hit_size,
  output logic [OUTC_W-1:0]      out_evicted,
  output logic [OUTC_W-1:0]      out_entries_held,
  output logic [MAXB_W-1:0]      out_bytes_held,
  input  wire logic              cfg_we,
  input  wire logic [CFGI_W-1:0] cfg_index,
  input  wire logic [MAXB_W-1:0] cfg_wdata
);

  hlc_cmd_t  cmd;
  hlc_stat_t stat;

  // sequencer
  hlc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_opcode(in_opcode),
    .out_stall(out_stall), .stat(stat), .cmd(cmd), .in_stall(in_stall)
  );

  // stores and counters
  hlc_dp #(.CAPACITY(CAPACITY), .BUCKETS(BUCKETS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_opcode(in_opcode), .in_key_low(in_key_low), .in_key_mid(in_key_mid),
    .in_key_high(in_key_high), .in_entry_size(in_entry_size),
    .out_stall(out_stall), .out_valid(out_valid), .out_found(out_found),
    .out_hit_size(out_hit_size), .out_evicted(out_evicted),
    .out_entries_held(out_entries_held), .out_bytes_held(out_bytes_held)
  );

endmodule
`default_nettype wire

// ===== rtl/core/hlc_checker.sv =====
// port level checks of the hashed lru tag store and their binding
`default_nettype none
module hlc_checker
  import hlc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [OPC_W-1:0]  in_opcode,
  input wire logic [63:0]       in_key_low,
  input wire logic [63:0]       in_key_mid,
  input wire logic [31:0]       in_key_high,
  input wire logic [SIZE_W-1:0] in_entry_size,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_found,
  input wire logic [SIZE_W-1:0] out_hit_size,
  input wire logic [OUTC_W-1:0] out_evicted,
  input wire logic [OUTC_W-1:0] out_entries_held,
  input wire logic [MAXB_W-1:0] out_bytes_held,
  input wire logic              cfg_we,
  input wire logic [CFGI_W-1:0] cfg_index,
  input wire logic [MAXB_W-1:0] cfg_wdata
);

  // bucket heads are being cleared right after reset
  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("item taken during the post-reset clear");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) &&
    $stable(out_hit_size) && $stable(out_evicted) && $stable(out_bytes_held))
    else $error("stalled result changed");

  // a miss reports no size
  a_miss_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_hit_size == '0)
    else $error("miss with nonzero size");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_evicted == '0)
    else $error("hit reported evictions");

endmodule

bind hashed_lru_cache_with_byte_budget hlc_checker u_hlc_checker (.*);
`default_nettype wire
